[hw/rtl/csdi_pkg.sv]
// Package for the cable spring-damper impulse block.
// Holds the sequencer state type, register indexes and fixed widths.
// No dependencies.
package csdi_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 2'd2;

  // Magnitude cap applied to the damping force before the clamp.
  localparam logic [63:0] MAG_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

  // Step counts of the shared divide and root unit.
  localparam logic [6:0] SQRT_STEPS = 7'd34;
  localparam logic [6:0] VEL_STEPS  = 7'd64;
  localparam logic [6:0] IMP_STEPS  = 7'd32;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_LEN,
    ST_SPR,
    ST_VEL,
    ST_DMP,
    ST_TOT,
    ST_TMUL,
    ST_IMUL,
    ST_IDIV,
    ST_WRITE
  } state_t;

endpackage

[hw/rtl/cable_spring_damper_impulse.sv]
// Cable spring-damper impulse block, top level.
// Depends on csdi_pkg for the state type, register indexes and constants.
//
// Each item carries two anchor positions and a time step and is worked by one
// shared bit-serial unit: multiplies retire one multiplier bit per cycle and
// end as soon as the remaining multiplier bits are zero (three squares,
// spring, damping, force times step, and three components), while the square
// root takes 34 steps, the velocity divide 64 steps and each impulse divide 32
// steps. The block takes no new item while one is in work; a finished result
// waits in the output register, so the next item can be accepted before it is
// taken. A result that is still waiting when the next one finishes holds the
// block until it is taken.
module cable_spring_damper_impulse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             in_first_x,
  input  logic signed [31:0]             in_first_y,
  input  logic signed [31:0]             in_first_z,
  input  logic signed [31:0]             in_second_x,
  input  logic signed [31:0]             in_second_y,
  input  logic signed [31:0]             in_second_z,
  input  logic [31:0]                    in_time_step,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_impulse_x,
  output logic signed [31:0]             out_impulse_y,
  output logic signed [31:0]             out_impulse_z,
  output logic [31:0]                    out_cable_length,
  output logic [31:0]                    out_tension,
  output logic                           out_taut
);

  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  csdi_pkg::state_t state_r, state_nxt;

  logic [31:0] stiff_r, coef_r;
  logic [30:0] rest_r;

  logic [32:0] dmag_r [3];
  logic        dneg_r [3];
  logic [31:0] dt_r;

  logic [127:0] acc_r, ma_r;
  logic [33:0]  mb_r;
  logic [67:0]  num_r;
  logic [36:0]  rem_r;
  logic [63:0]  q_r;
  logic [33:0]  den_r;
  logic [6:0]   cnt_r;
  logic [1:0]   comp_r;

  logic [33:0] len_r, dlmag_r;
  logic        taut_r, dlneg_r, sat_r;
  logic [63:0] spring_r, dampf_r;
  logic [90:0] tdt_r;
  logic [31:0] imp_r [3];

  logic [31:0] prev_len_r;
  logic        have_prev_r;
  logic        out_valid_r;

  // Anchor differences at the input.
  logic signed [32:0] diff [3];
  logic [32:0]        diff_mag [3];
  assign diff[0] = 33'(in_second_x) - 33'(in_first_x);
  assign diff[1] = 33'(in_second_y) - 33'(in_first_y);
  assign diff[2] = 33'(in_second_z) - 33'(in_first_z);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_mag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
    end
  end

  // Shared multiply step: add the multiplicand when the low multiplier bit is set.
  logic         mul_done;
  logic [127:0] mul_acc;
  assign mul_done = (mb_r == '0);
  assign mul_acc  = acc_r + (mb_r[0] ? ma_r : 128'd0);

  // Shared divide step and root step on the same remainder register.
  logic [36:0] div_try, sqrt_try, sqrt_trial;
  logic        div_ge, sqrt_ge;
  assign div_try    = {rem_r[35:0], num_r[67]};
  assign div_ge     = div_try >= {3'b0, den_r};
  assign sqrt_try   = {rem_r[34:0], num_r[67:66]};
  assign sqrt_trial = {1'b0, q_r[33:0], 2'b01};
  assign sqrt_ge    = sqrt_try >= sqrt_trial;

  // Product scaled down by the fraction bits.
  logic [127:0] acc_sh;
  logic [63:0]  damp_cap;
  assign acc_sh   = acc_r >> FRAC_BITS;
  assign damp_cap = (acc_sh[127:62] != '0) ? csdi_pkg::MAG_CAP : acc_sh[63:0];

  // Length-derived values.
  logic [33:0] prev_len, rest_ext;
  assign rest_ext = {3'b0, rest_r};
  assign prev_len = have_prev_r ? {2'b0, prev_len_r} : rest_ext;

  // Impulse component saturation; a slack cable gives no impulse.
  logic [1:0]  comp_inc;
  logic [31:0] imp_val;
  logic        imp_neg;
  assign comp_inc = comp_r + 2'd1;
  assign imp_neg  = dneg_r[comp_r];
  always_comb begin
    if (!taut_r) begin
      imp_val = '0;
    end else if (imp_neg) begin
      imp_val = (sat_r || q_r[31:0] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_r[31:0]);
    end else begin
      imp_val = (sat_r || q_r[31]) ? 32'h7FFF_FFFF : q_r[31:0];
    end
  end

  logic write_go;
  assign write_go = !out_valid_r || out_ready;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csdi_pkg::ST_IDLE:  if (in_valid) state_nxt = csdi_pkg::ST_SQ;
      csdi_pkg::ST_SQ:    if (mul_done && comp_r == 2'd2) state_nxt = csdi_pkg::ST_SQRT;
      csdi_pkg::ST_SQRT:  if (cnt_r == '0) state_nxt = csdi_pkg::ST_LEN;
      csdi_pkg::ST_LEN:   state_nxt = csdi_pkg::ST_SPR;
      csdi_pkg::ST_SPR:   if (mul_done) state_nxt = csdi_pkg::ST_VEL;
      csdi_pkg::ST_VEL:   if (cnt_r == '0) state_nxt = csdi_pkg::ST_DMP;
      csdi_pkg::ST_DMP:   if (mul_done) state_nxt = csdi_pkg::ST_TOT;
      csdi_pkg::ST_TOT:   state_nxt = csdi_pkg::ST_TMUL;
      csdi_pkg::ST_TMUL:  if (mul_done) state_nxt = csdi_pkg::ST_IMUL;
      csdi_pkg::ST_IMUL:  if (mul_done) state_nxt = csdi_pkg::ST_IDIV;
      csdi_pkg::ST_IDIV: begin
        if (cnt_r == '0) begin
          state_nxt = (comp_r == 2'd2) ? csdi_pkg::ST_WRITE : csdi_pkg::ST_IMUL;
        end
      end
      csdi_pkg::ST_WRITE: if (write_go) state_nxt = csdi_pkg::ST_IDLE;
      default:            state_nxt = csdi_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csdi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= ONE_Q;
      coef_r  <= '0;
      rest_r  <= ONE_Q[30:0];
    end else if (cfg_valid) begin
      case (cfg_index)
        csdi_pkg::REG_STIFFNESS: stiff_r <= cfg_data;
        csdi_pkg::REG_DAMPING:   coef_r  <= cfg_data;
        csdi_pkg::REG_REST_LEN:  rest_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Datapath of the shared unit, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state_r)
      csdi_pkg::ST_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < 3; i++) begin
            dmag_r[i] <= diff_mag[i];
            dneg_r[i] <= diff[i][32];
          end
          dt_r   <= in_time_step;
          acc_r  <= '0;
          ma_r   <= 128'(diff_mag[0]);
          mb_r   <= 34'(diff_mag[0]);
          comp_r <= '0;
        end
      end
      csdi_pkg::ST_SQ: begin
        if (!mul_done) begin
          acc_r <= mul_acc;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end else if (comp_r != 2'd2) begin
          comp_r <= comp_inc;
          ma_r   <= 128'(dmag_r[comp_inc]);
          mb_r   <= 34'(dmag_r[comp_inc]);
        end else begin
          num_r <= {2'b0, acc_r[65:0]};
          rem_r <= '0;
          q_r   <= '0;
          cnt_r <= csdi_pkg::SQRT_STEPS;
        end
      end
      csdi_pkg::ST_SQRT: begin
        if (cnt_r != '0) begin
          rem_r <= sqrt_ge ? sqrt_try - sqrt_trial : sqrt_try;
          q_r   <= {q_r[62:0], sqrt_ge};
          num_r <= num_r << 2;
          cnt_r <= cnt_r - 7'd1;
        end else begin
          len_r <= q_r[33:0];
        end
      end
      csdi_pkg::ST_LEN: begin
        taut_r  <= len_r > rest_ext;
        dlneg_r <= len_r < prev_len;
        dlmag_r <= (len_r < prev_len) ? prev_len - len_r : len_r - prev_len;
        acc_r   <= '0;
        ma_r    <= 128'(stiff_r);
        mb_r    <= (len_r > rest_ext) ? len_r - rest_ext : rest_ext - len_r;
      end
      csdi_pkg::ST_SPR: begin
        if (!mul_done) begin
          acc_r <= mul_acc;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end else begin
          spring_r <= acc_sh[63:0];
          num_r    <= {6'b0, dlmag_r, 28'b0};
          rem_r    <= '0;
          q_r      <= '0;
          den_r    <= {2'b0, dt_r};
          cnt_r    <= csdi_pkg::VEL_STEPS;
        end
      end
      csdi_pkg::ST_VEL: begin
        if (cnt_r != '0) begin
          rem_r <= div_ge ? div_try - {3'b0, den_r} : div_try;
          q_r   <= {q_r[62:0], div_ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 7'd1;
        end else begin
          // A zero time step gives zero velocity.
          acc_r <= '0;
          ma_r  <= (dt_r == '0) ? 128'd0 : 128'(q_r);
          mb_r  <= 34'(coef_r);
        end
      end
      csdi_pkg::ST_DMP: begin
        if (!mul_done) begin
          acc_r <= mul_acc;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end else begin
          dampf_r <= (damp_cap > spring_r) ? spring_r : damp_cap;
        end
      end
      csdi_pkg::ST_TOT: begin
        // Total force is zero on a slack cable.
        acc_r <= '0;
        if (!taut_r) begin
          ma_r <= '0;
        end else if (dlneg_r) begin
          ma_r <= 128'(spring_r - dampf_r);
        end else begin
          ma_r <= 128'(spring_r + dampf_r);
        end
        mb_r <= 34'(dt_r);
      end
      csdi_pkg::ST_TMUL: begin
        if (!mul_done) begin
          acc_r <= mul_acc;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end else begin
          tdt_r  <= acc_r[90:0];
          comp_r <= '0;
          acc_r  <= '0;
          ma_r   <= 128'(acc_r[90:0]);
          mb_r   <= 34'(dmag_r[0]);
        end
      end
      csdi_pkg::ST_IMUL: begin
        if (!mul_done) begin
          acc_r <= mul_acc;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
        end else begin
          // Quotient needs more than 32 bits when the upper part reaches the length.
          sat_r <= acc_r[123:56] >= 68'(len_r);
          rem_r <= {3'b0, acc_r[89:56]};
          num_r <= {acc_r[55:24], 36'b0};
          q_r   <= '0;
          den_r <= len_r;
          cnt_r <= csdi_pkg::IMP_STEPS;
        end
      end
      csdi_pkg::ST_IDIV: begin
        if (cnt_r != '0) begin
          rem_r <= div_ge ? div_try - {3'b0, den_r} : div_try;
          q_r   <= {q_r[62:0], div_ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 7'd1;
        end else begin
          imp_r[comp_r] <= imp_val;
          if (comp_r != 2'd2) begin
            comp_r <= comp_inc;
            acc_r  <= '0;
            ma_r   <= 128'(tdt_r);
            mb_r   <= 34'(dmag_r[comp_inc]);
          end
        end
      end
      default: ;
    endcase
  end

  // Result register and the stored length of the previous step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_len_r  <= '0;
      have_prev_r <= 1'b0;
    end else if (state_r == csdi_pkg::ST_WRITE && write_go) begin
      out_valid_r <= 1'b1;
      prev_len_r  <= (len_r[33:32] != '0) ? 32'hFFFF_FFFF : len_r[31:0];
      have_prev_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == csdi_pkg::ST_WRITE && write_go) begin
      out_impulse_x    <= imp_r[0];
      out_impulse_y    <= imp_r[1];
      out_impulse_z    <= imp_r[2];
      out_cable_length <= (len_r[33:32] != '0) ? 32'hFFFF_FFFF : len_r[31:0];
      out_tension      <= !taut_r ? 32'd0 :
                          (spring_r[63:32] != '0) ? 32'hFFFF_FFFF : spring_r[31:0];
      out_taut         <= taut_r;
    end
  end

  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == csdi_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

endmodule

[hw/rtl/csdi_checker.sv]
// Port-level checker for the cable spring-damper impulse block.
// Depends on cable_spring_damper_impulse; bound to it at the end of this file.
module csdi_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_impulse_x,
  input logic [31:0] out_impulse_y,
  input logic [31:0] out_impulse_z,
  input logic [31:0] out_cable_length,
  input logic [31:0] out_tension,
  input logic        out_taut
);

  // A waiting result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // The block is busy right after taking an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  // A slack cable gives no impulse and no tension.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_taut |-> out_impulse_x == '0 && out_impulse_y == '0 &&
                               out_impulse_z == '0 && out_tension == '0)
    else $error("slack cable with nonzero force");

  // A taut cable has a nonzero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_taut |-> out_cable_length != '0)
    else $error("taut cable with zero length");

endmodule

bind cable_spring_damper_impulse csdi_props u_csdi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_impulse_x    (out_impulse_x),
  .out_impulse_y    (out_impulse_y),
  .out_impulse_z    (out_impulse_z),
  .out_cable_length (out_cable_length),
  .out_tension      (out_tension),
  .out_taut         (out_taut)
);
